[hw/rtl/pporf_pkg.sv]
`timescale 1ns / 1ps

package pporf_pkg;

    localparam int MAX_CODES_DEF        = 16;
    localparam int MAX_OPTION_BYTES_DEF = 1024;

    // The two code list registers hold eight one-byte entries each.
    localparam int CODE_W          = 8;
    localparam int CODES_PER_REG   = 8;
    localparam int CODE_SLOTS      = 16;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 4;

    localparam int LEN_W           = 11;
    localparam int LEN_SUM_W       = 13;
    localparam int HDR_BYTES       = 4;
    localparam int LEN_MAX         = 2047;
    localparam int MIN_OPT_LEN     = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_CODES_LOW  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CODES_HIGH = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        PHASE_CODE = 2'd0,
        PHASE_LEN  = 2'd1,
        PHASE_BODY = 2'd2
    } phase_t;

endpackage

[hw/rtl/ppp_option_reject_filter.sv]
`timescale 1ns / 1ps
// Path: an accepted byte passes the input register, then the result register,
// before its result shows on the m_ side.
// Throughput: one byte per cycle while m_ready drains the result register;
// bytes with no result drop at the input register and skip the result register.
// Reset: synchronous, active low; clears the code list, the parse state and
// both valid flags. No clearing pass is needed.
module ppp_option_reject_filter #(
    parameter int MAX_CODES        = pporf_pkg::MAX_CODES_DEF,
    parameter int MAX_OPTION_BYTES = pporf_pkg::MAX_OPTION_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pporf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pporf_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_in_byte,
    input  logic                                s_is_last,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_byte_valid,
    output logic                                m_done_res,
    output logic                                m_rejected,
    output logic [pporf_pkg::LEN_W-1:0]         m_reject_length
);

    localparam int COUNT_W = $clog2(MAX_OPTION_BYTES + 1);

    logic [pporf_pkg::CFG_DATA_W-1:0] codes_low_reg;
    logic [pporf_pkg::CFG_DATA_W-1:0] codes_high_reg;
    logic [pporf_pkg::CODE_W-1:0]     code_list [pporf_pkg::CODE_SLOTS];

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    pporf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]         rem_reg, rem_next;
    logic               copying_reg, copying_next;
    logic               any_rej_reg, any_rej_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic       out_vld_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvld_reg;
    logic       out_done_reg;
    logic       out_rej_reg;
    logic [pporf_pkg::LEN_W-1:0] out_len_reg;

    logic       supported;
    logic       copy;
    logic       code_rej;
    logic       has_result;
    logic       advance;
    logic       load;
    logic [7:0] len_byte;
    logic [pporf_pkg::LEN_SUM_W-1:0] len_sum;
    logic [pporf_pkg::LEN_W-1:0]     len_sat;

    // Configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_low_reg  <= '0;
            codes_high_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == pporf_pkg::REG_CODES_LOW) begin
                codes_low_reg <= cfg_data;
            end else if (cfg_index == pporf_pkg::REG_CODES_HIGH) begin
                codes_high_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < pporf_pkg::CODES_PER_REG; k++) begin
            code_list[k] = codes_low_reg[k*pporf_pkg::CODE_W +: pporf_pkg::CODE_W];
            code_list[k+pporf_pkg::CODES_PER_REG] =
                codes_high_reg[k*pporf_pkg::CODE_W +: pporf_pkg::CODE_W];
        end
    end

    // The list ends at its first zero entry, so a match only counts while
    // every earlier entry was nonzero. A code of zero therefore never matches.
    always_comb begin
        logic alive;
        alive     = 1'b1;
        supported = 1'b0;
        for (int k = 0; k < MAX_CODES; k++) begin
            if (alive && code_list[k] != '0 && code_list[k] == in_byte_reg) begin
                supported = 1'b1;
            end
            alive = alive && (code_list[k] != '0);
        end
    end

    // Input register
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_is_last;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= pporf_pkg::PHASE_CODE;
            rem_reg     <= '0;
            copying_reg <= 1'b0;
            any_rej_reg <= 1'b0;
            count_reg   <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            rem_reg     <= rem_next;
            copying_reg <= copying_next;
            any_rej_reg <= any_rej_next;
            count_reg   <= count_next;
        end
    end

    assign len_byte = (in_byte_reg < 8'(pporf_pkg::MIN_OPT_LEN)) ?
                      8'(pporf_pkg::MIN_OPT_LEN) : in_byte_reg;

    always_comb begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        copying_next = copying_reg;
        any_rej_next = any_rej_reg;
        count_next   = count_reg;
        copy         = 1'b0;
        code_rej     = 1'b0;
        case (phase_reg)
            pporf_pkg::PHASE_LEN: begin
                copy       = copying_reg;
                rem_next   = len_byte - 8'(pporf_pkg::MIN_OPT_LEN);
                phase_next = (rem_next != '0) ? pporf_pkg::PHASE_BODY
                                              : pporf_pkg::PHASE_CODE;
            end
            pporf_pkg::PHASE_BODY: begin
                copy = copying_reg;
                if (rem_reg != '0) begin
                    rem_next = rem_reg - 8'd1;
                end
                if (rem_next == '0) begin
                    phase_next = pporf_pkg::PHASE_CODE;
                end
            end
            default: begin
                copying_next = !supported;
                code_rej     = !supported;
                if (!supported) begin
                    any_rej_next = 1'b1;
                end
                copy       = !supported;
                phase_next = pporf_pkg::PHASE_LEN;
            end
        endcase

        // Once the reject body is full, further bytes are dropped uncounted.
        if (copy) begin
            if (count_reg < COUNT_W'(MAX_OPTION_BYTES)) begin
                count_next = count_reg + COUNT_W'(1);
            end else begin
                copy = 1'b0;
            end
        end

        len_sum = pporf_pkg::LEN_SUM_W'(count_next) + pporf_pkg::LEN_SUM_W'(pporf_pkg::HDR_BYTES);
        len_sat = (len_sum > pporf_pkg::LEN_SUM_W'(pporf_pkg::LEN_MAX)) ?
                  pporf_pkg::LEN_W'(pporf_pkg::LEN_MAX) : len_sum[pporf_pkg::LEN_W-1:0];

        if (in_last_reg) begin
            phase_next   = pporf_pkg::PHASE_CODE;
            rem_next     = '0;
            copying_next = 1'b0;
            any_rej_next = 1'b0;
            count_next   = '0;
        end
    end

    // Result register
    assign has_result = copy || in_last_reg;
    assign advance    = in_vld_reg && (!has_result || !out_vld_reg || m_ready);
    assign load       = advance && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (load) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= copy ? in_byte_reg : 8'd0;
            out_bvld_reg <= copy;
            out_done_reg <= in_last_reg;
            out_rej_reg  <= in_last_reg && (any_rej_reg || code_rej);
            out_len_reg  <= in_last_reg ? len_sat : '0;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_byte_valid    = out_bvld_reg;
    assign m_done_res      = out_done_reg;
    assign m_rejected      = out_rej_reg;
    assign m_reject_length = out_len_reg;

`ifndef SYNTHESIS
    // A result that does not end the packet exists only to carry a byte.
    a_result_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_byte_valid)
        else $error("result with neither byte nor done");

    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_out_byte == 8'd0)
        else $error("out_byte nonzero without byte_valid");

    // Bytes are copied only from rejected options.
    a_no_reject_no_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res && !m_rejected |->
            m_reject_length == pporf_pkg::LEN_W'(pporf_pkg::HDR_BYTES))
        else $error("bytes counted without a rejected option");

    a_body_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == pporf_pkg::PHASE_BODY |-> rem_reg != 8'd0)
        else $error("body phase with no bytes remaining");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_OPTION_BYTES))
        else $error("copied count beyond limit");
`endif

endmodule
